// ===== rtl/tvp_pkg.sv =====
// ----------------------------------------------------------------------------
// tvp_pkg
// Shared types and constants of the trapezoidal velocity profiler: channel
// payloads, profile phase codes and configuration register indexes.
// ----------------------------------------------------------------------------
package tvp_pkg;

  localparam int unsigned PosW    = 32;  // signed fixed-point position
  localparam int unsigned VelW    = 32;  // signed fixed-point velocity
  localparam int unsigned CfgW    = 31;  // width of the numeric registers
  localparam int unsigned PhaseW  = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;

  // serial multiplier geometry: 32-bit multiplicand, 34-bit multiplier
  localparam int unsigned MulAW = 32;
  localparam int unsigned MulBW = 34;
  localparam int unsigned MulPW = MulAW + MulBW;

  localparam logic [CfgW-1:0] MaxVelRst    = 31'd3932160;
  localparam logic [CfgW-1:0] AccelRateRst = 31'd13107200;
  localparam logic [CfgW-1:0] AccelStepRst = 31'd13107;
  localparam logic [CfgW-1:0] DeadbandRst  = 31'd3277;

  typedef enum logic [PhaseW-1:0] {
    PH_NONE      = 4'd0,
    PH_UP_ACCEL  = 4'd1,
    PH_UP_CRUISE = 4'd2,
    PH_UP_DECEL  = 4'd3,
    PH_UP_ZERO   = 4'd4,
    PH_DN_ACCEL  = 4'd5,
    PH_DN_CRUISE = 4'd6,
    PH_DN_DECEL  = 4'd7,
    PH_DN_ZERO   = 4'd8,
    PH_HOLD      = 4'd9
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_VELOCITY = 3'd0,
    CFG_ACCEL_RATE   = 3'd1,
    CFG_ACCEL_STEP   = 3'd2,
    CFG_DEADBAND     = 3'd3,
    CFG_AUTO_HOLD    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [PosW-1:0] measured_position;
    logic signed [PosW-1:0] target_position;
    logic                   new_target;
  } in_item_t;

  typedef struct packed {
    logic signed [VelW-1:0] velocity_command;
    logic [PhaseW-1:0]      profile_phase;
    logic                   arrived;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] addr;
    logic [CfgDatW-1:0] wdata;
  } cfg_item_t;

endpackage

// ===== rtl/tvp_stream_if.sv =====
// ----------------------------------------------------------------------------
// tvp_stream_if
// Valid/ready channel carrying one payload item of type T per handshake.
// ----------------------------------------------------------------------------
interface tvp_stream_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ===== rtl/tvp_digit_mul.sv =====
// ----------------------------------------------------------------------------
// tvp_digit_mul
// Radix-4 digit-serial shift-add multiplier: one 2-bit digit of the
// multiplier per cycle, product shifts in from the top of the low word.
// ----------------------------------------------------------------------------
module tvp_digit_mul #(
  parameter int unsigned AW = 32,  // multiplicand width
  parameter int unsigned BW = 34   // multiplier width, even
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AW-1:0]   mcand_i,
  input  logic [BW-1:0]   mplier_i,
  output logic [AW+BW-1:0] prod_o,
  output logic            done_o
);

  localparam int unsigned Steps = BW / 2;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [AW-1:0]   hi_q;
  logic [BW-1:0]   lo_q;
  logic [AW-1:0]   mcd_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [AW+1:0]   sum;

  // partial sum stays below 4 * 2^AW, so the upper word never overflows
  always_comb begin
    sum = {2'b00, hi_q}
        + (lo_q[0] ? {2'b00, mcd_q} : '0)
        + (lo_q[1] ? {1'b0, mcd_q, 1'b0} : '0);
  end

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CntW'(Steps);
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q  <= '0;
      lo_q  <= mplier_i;
      mcd_q <= mcand_i;
    end else if (cnt_q != '0) begin
      hi_q <= sum[AW+1:2];
      lo_q <= {sum[1:0], lo_q[BW-1:2]};
    end
  end

  assign prod_o = {hi_q, lo_q};
  assign done_o = done_q;

  a_start_loads_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> cnt_q == CntW'(Steps))
    else $error("digit counter not loaded on start");

  a_done_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> cnt_q == '0)
    else $error("done raised while digits remain");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cnt_q) == CntW'(1))
    else $error("done raised without a last digit step");

endmodule

// ===== rtl/trapezoid_velocity_profiler_core.sv =====
// ----------------------------------------------------------------------------
// trapezoid_velocity_profiler_core
// Trapezoidal velocity profile generator: one velocity command and profile
// phase per control tick, braking check done by two digit-serial multipliers.
// ----------------------------------------------------------------------------
// an accepted item runs S_ERR, S_RAMP, S_LOAD, S_MUL, S_FIN; no new item is
// taken until its result is loaded; S_MUL covers the 17 radix-4 digit steps of
//   the two serial multipliers (v*v and error*2*accel) running side by side
// a stalled output holds the finishing stage until the result slot frees
// reset: velocity 0, phase none, registers at their documented defaults
module trapezoid_velocity_profiler_core
  import tvp_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  tvp_stream_if.sink   in_i,
  tvp_stream_if.source out_o,
  tvp_stream_if.sink   cfg_i
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ERR  = 6'b000010,
    S_RAMP = 6'b000100,
    S_LOAD = 6'b001000,
    S_MUL  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  function automatic logic [VelW-1:0] sat_vel(input logic [VelW+1:0] x);
    logic [VelW-1:0] r;
    if (x[VelW+1:VelW-1] == 3'b000 || x[VelW+1:VelW-1] == 3'b111) begin
      r = x[VelW-1:0];
    end else if (x[VelW+1]) begin
      r = {1'b1, {(VelW-1){1'b0}}};
    end else begin
      r = {1'b0, {(VelW-1){1'b1}}};
    end
    return r;
  endfunction

  state_e state_q, state_d;

  // configuration
  logic [CfgW-1:0] max_vel_q, accel_rate_q, accel_step_q, deadband_q;
  logic            auto_hold_q;

  // profile state
  logic [VelW-1:0] velocity_q;
  phase_e          phase_q;

  // per-item work registers
  logic [PosW:0]   err_q, nerr_q;
  logic            newt_q;
  logic [PosW:0]   aerr_q;
  logic            arr_q;
  logic [VelW-1:0] wv_q;
  phase_e          wph_q;

  // output slot
  logic      out_valid_q;
  out_item_t out_data_q;

  logic [PosW:0]   meas_x, tgt_x;
  logic [PosW:0]   aerr;
  logic            arrived, far;
  phase_e          ph0, ph1;
  logic [VelW-1:0] v1;

  logic [VelW-1:0] vmax, neg_vmax, v_plus, v_minus, va;
  logic [VelW:0]   rng;
  logic            above_neg;
  phase_e          pha;

  logic [VelW-1:0]  sq_mcand;
  logic             mul_start;
  logic [MulPW-1:0] sq_prod, pd_prod;
  logic             sq_done, pd_done;

  logic            s_ge_p, err_ge0, err_le0;
  logic [VelW-1:0] vf;
  phase_e          phf;
  logic            out_load;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // error and its negation both taken at capture, so the magnitude is a select
  assign meas_x = {in_i.data.measured_position[PosW-1], in_i.data.measured_position};
  assign tgt_x  = {in_i.data.target_position[PosW-1], in_i.data.target_position};

  // arrival test and phase selection
  always_comb begin
    aerr    = err_q[PosW] ? nerr_q : err_q;
    arrived = aerr < {2'b00, deadband_q};
    far     = aerr > {2'b00, deadband_q};
    ph0     = newt_q ? PH_UP_ZERO : phase_q;
    ph1     = ph0;
    v1      = velocity_q;
    if (ph0 != PH_HOLD) begin
      if (arrived) begin
        v1 = '0;
        if (auto_hold_q) begin
          ph1 = PH_HOLD;
        end
      end else if (far) begin
        ph1 = err_q[PosW] ? PH_UP_ACCEL : PH_DN_ACCEL;
      end
    end
  end

  // ramp up to cruise, or step along the acceleration
  always_comb begin
    vmax      = {1'b0, max_vel_q};
    neg_vmax  = ~{1'b0, max_vel_q} + VelW'(1);
    v_plus    = sat_vel({wv_q[VelW-1], wv_q[VelW-1], wv_q} + {3'b000, accel_step_q});
    v_minus   = sat_vel({wv_q[VelW-1], wv_q[VelW-1], wv_q} - {3'b000, accel_step_q});
    rng       = {wv_q[VelW-1], wv_q} + {2'b00, max_vel_q};
    above_neg = !rng[VelW] && (rng != '0);
    va        = wv_q;
    pha       = wph_q;
    if (wph_q == PH_UP_ACCEL && $signed(wv_q) < $signed(vmax)) begin
      va = v_plus;
    end else if (wph_q == PH_UP_ACCEL || wph_q == PH_UP_CRUISE) begin
      pha = PH_UP_CRUISE;
      va  = vmax;
    end
    if (wph_q == PH_DN_ACCEL && above_neg) begin
      va = v_minus;
    end else if (wph_q == PH_DN_ACCEL || wph_q == PH_DN_CRUISE) begin
      pha = PH_DN_CRUISE;
      va  = neg_vmax;
    end
  end

  // braking distance test: floor(v*v / 2a) >= e  <=>  v*v >= e * 2a
  assign mul_start = (state_q == S_LOAD);
  assign sq_mcand  = wv_q[VelW-1] ? (~wv_q + VelW'(1)) : wv_q;

  tvp_digit_mul #(
    .AW(MulAW),
    .BW(MulBW)
  ) u_sq_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mcand_i (sq_mcand),
    .mplier_i({2'b00, sq_mcand}),
    .prod_o  (sq_prod),
    .done_o  (sq_done)
  );

  tvp_digit_mul #(
    .AW(MulAW),
    .BW(MulBW)
  ) u_dist_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mcand_i ({accel_rate_q, 1'b0}),
    .mplier_i({1'b0, aerr_q}),
    .prod_o  (pd_prod),
    .done_o  (pd_done)
  );

  // deceleration and end-of-ramp clamp; wv_q holds the ramped velocity here
  always_comb begin
    s_ge_p  = sq_prod >= pd_prod;
    err_ge0 = !err_q[PosW];
    err_le0 = err_q[PosW] || (err_q == '0);
    vf      = wv_q;
    phf     = wph_q;
    if (!vf[VelW-1] && vf != '0 && (err_ge0 || s_ge_p)) begin
      if (phf == PH_UP_CRUISE || phf == PH_UP_ACCEL) begin
        phf = PH_UP_DECEL;
      end
      if (phf == PH_UP_DECEL) begin
        vf = v_minus;
      end
    end
    if (vf[VelW-1] || vf == '0) begin
      if (phf == PH_UP_DECEL) begin
        phf = PH_UP_ZERO;
      end
      if (phf == PH_UP_ZERO) begin
        vf = '0;
      end
    end
    if (vf[VelW-1] && (err_le0 || s_ge_p)) begin
      if (phf == PH_DN_CRUISE || phf == PH_DN_ACCEL) begin
        phf = PH_DN_DECEL;
      end
      if (phf == PH_DN_DECEL) begin
        vf = v_plus;
      end
    end
    if (!vf[VelW-1]) begin
      if (phf == PH_DN_DECEL) begin
        phf = PH_DN_ZERO;
      end
      if (phf == PH_DN_ZERO) begin
        vf = '0;
      end
    end
    if (phf == PH_HOLD) begin
      vf = '0;
    end
  end

  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_ERR;
        end
      end
      S_ERR:  state_d = S_RAMP;
      S_RAMP: state_d = S_LOAD;
      S_LOAD: state_d = S_MUL;
      S_MUL: begin
        if (sq_done && pd_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      velocity_q   <= '0;
      phase_q      <= PH_NONE;
      out_valid_q  <= 1'b0;
      max_vel_q    <= MaxVelRst;
      accel_rate_q <= AccelRateRst;
      accel_step_q <= AccelStepRst;
      deadband_q   <= DeadbandRst;
      auto_hold_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        velocity_q  <= vf;
        phase_q     <= phf;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_idx_e'(cfg_i.data.addr))
          CFG_MAX_VELOCITY: max_vel_q    <= cfg_i.data.wdata[CfgW-1:0];
          CFG_ACCEL_RATE:   accel_rate_q <= cfg_i.data.wdata[CfgW-1:0];
          CFG_ACCEL_STEP:   accel_step_q <= cfg_i.data.wdata[CfgW-1:0];
          CFG_DEADBAND:     deadband_q   <= cfg_i.data.wdata[CfgW-1:0];
          CFG_AUTO_HOLD:    auto_hold_q  <= cfg_i.data.wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && state_q == S_IDLE) begin
      err_q  <= meas_x - tgt_x;
      nerr_q <= tgt_x - meas_x;
      newt_q <= in_i.data.new_target;
    end
    if (state_q == S_ERR) begin
      aerr_q <= aerr;
      arr_q  <= arrived;
      wv_q   <= v1;
      wph_q  <= ph1;
    end
    if (state_q == S_RAMP) begin
      wv_q  <= va;
      wph_q <= pha;
    end
    if (out_load) begin
      out_data_q.velocity_command <= vf;
      out_data_q.profile_phase    <= phf;
      out_data_q.arrived          <= arr_q;
    end
  end

  a_hold_means_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HOLD |-> velocity_q == '0)
    else $error("hold phase with nonzero velocity");

  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_HOLD)
    else $error("profile phase code out of range");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result item raised outside the finishing stage");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for trapezoid_velocity_profiler_core. Control ticks go in over a
// valid/ready channel with random gaps, and the velocity commands come back
// with random stalls. A local profile predictor holds its own velocity, phase
// and register copies and queues one expected command per accepted tick.
// Each returned command is checked field by field. Directed ticks cover the
// edge cases, and random moves run a crude plant that follows the commanded
// velocity under several register settings.
// ----------------------------------------------------------------------------
module tb;
  import tvp_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainCycles = 30;
  localparam longint Int32Max = 64'sd2147483647;
  localparam longint Int32Min = -64'sd2147483648;
  localparam longint BrakeUnbounded = 64'sh4000_0000_0000_0000;

  logic clk;
  logic rst_n;

  tvp_stream_if #(.T(in_item_t))  tick_if ();
  tvp_stream_if #(.T(out_item_t)) cmd_if ();
  tvp_stream_if #(.T(cfg_item_t)) cfg_if ();

  trapezoid_velocity_profiler_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (tick_if),
    .out_o  (cmd_if),
    .cfg_i  (cfg_if)
  );

  // predictor state and register copies
  logic [CfgW-1:0]        max_vel_q;
  logic [CfgW-1:0]        accel_rate_q;
  logic [CfgW-1:0]        accel_step_q;
  logic [CfgW-1:0]        deadband_q;
  logic                   auto_hold_q;
  logic signed [VelW-1:0] vel_q;
  phase_e                 phase_q;

  out_item_t   pending_cmds[$];
  int unsigned ticks_sent;
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 9);
  endfunction

  function automatic logic signed [31:0] sat32(longint x);
    if (x > Int32Max) return 32'sh7FFF_FFFF;
    if (x < Int32Min) return 32'sh8000_0000;
    return 32'(x);
  endfunction

  // floor(v*v / (2*accel_rate)) in raw units
  function automatic longint brake_len(logic signed [31:0] v);
    longint     mag;
    logic [63:0] sq;
    logic [63:0] den;
    if (accel_rate_q == '0) return BrakeUnbounded;
    mag = longint'(v);
    if (mag < 0) mag = -mag;
    sq = 64'(mag * mag);
    den = 64'(accel_rate_q) << 1;
    return longint'(sq / den);
  endfunction

  function automatic void ramp_velocity(longint meas, longint tgt);
    longint                 vmax;
    longint                 stp;
    logic signed [VelW-1:0] v;
    phase_e                 p;
    vmax = longint'(max_vel_q);
    stp = longint'(accel_step_q);
    v = vel_q;
    p = phase_q;
    // upward half
    if (longint'(v) < vmax && p == PH_UP_ACCEL) begin
      v = sat32(longint'(v) + stp);
    end else begin
      if (p == PH_UP_ACCEL) p = PH_UP_CRUISE;
      if (p == PH_UP_CRUISE) v = 32'(vmax);
    end
    if (v > 0 && meas >= tgt - brake_len(v)) begin
      if (p == PH_UP_CRUISE || p == PH_UP_ACCEL) p = PH_UP_DECEL;
      if (p == PH_UP_DECEL) v = sat32(longint'(v) - stp);
    end
    if (v <= 0) begin
      if (p == PH_UP_DECEL) p = PH_UP_ZERO;
      if (p == PH_UP_ZERO) v = '0;
    end
    // downward half
    if (longint'(v) > -vmax && p == PH_DN_ACCEL) begin
      v = sat32(longint'(v) - stp);
    end else begin
      if (p == PH_DN_ACCEL) p = PH_DN_CRUISE;
      if (p == PH_DN_CRUISE) v = 32'(-vmax);
    end
    if (v < 0 && meas <= tgt + brake_len(v)) begin
      if (p == PH_DN_CRUISE || p == PH_DN_ACCEL) p = PH_DN_DECEL;
      if (p == PH_DN_DECEL) v = sat32(longint'(v) + stp);
    end
    if (v >= 0) begin
      if (p == PH_DN_DECEL) p = PH_DN_ZERO;
      if (p == PH_DN_ZERO) v = '0;
    end
    vel_q = v;
    phase_q = p;
  endfunction

  function automatic out_item_t advance_profile(in_item_t it);
    longint    meas;
    longint    tgt;
    longint    db;
    longint    err;
    logic      hit;
    out_item_t r;
    meas = longint'($signed(it.measured_position));
    tgt = longint'($signed(it.target_position));
    db = longint'(deadband_q);
    err = meas - tgt;
    if (err < 0) err = -err;
    hit = err < db;
    if (it.new_target) phase_q = PH_UP_ZERO;
    if (phase_q != PH_HOLD) begin
      if (hit) begin
        vel_q = '0;
        if (auto_hold_q) phase_q = PH_HOLD;
      end else if (meas < tgt - db) begin
        phase_q = PH_UP_ACCEL;
      end else if (meas > tgt + db) begin
        phase_q = PH_DN_ACCEL;
      end
      if (phase_q != PH_HOLD) ramp_velocity(meas, tgt);
    end
    if (phase_q == PH_HOLD) vel_q = '0;
    r.velocity_command = vel_q;
    r.profile_phase = phase_q;
    r.arrived = hit;
    return r;
  endfunction

  function automatic void check_cmd(out_item_t got);
    out_item_t want;
    if (pending_cmds.size() == 0) begin
      $error("unexpected velocity command %0d", $signed(got.velocity_command));
      mismatches++;
      return;
    end
    want = pending_cmds.pop_front();
    if (got.velocity_command !== want.velocity_command) begin
      $error("velocity_command: expected %0d, got %0d",
             $signed(want.velocity_command), $signed(got.velocity_command));
      mismatches++;
    end
    if (got.profile_phase !== want.profile_phase) begin
      $error("profile_phase: expected %0d, got %0d", want.profile_phase, got.profile_phase);
      mismatches++;
    end
    if (got.arrived !== want.arrived) begin
      $error("arrived: expected %0b, got %0b", want.arrived, got.arrived);
      mismatches++;
    end
  endfunction

  // result side: random stall before each command
  initial begin : cmd_sink
    int gap;
    cmd_if.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        cmd_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cmd_if.ready <= 1'b1;
      do @(posedge clk); while (!cmd_if.valid);
      check_cmd(cmd_if.data);
    end
  end

  // valid stays high after the item so back-to-back ticks need no re-raise
  task automatic send_tick(logic signed [31:0] meas, logic signed [31:0] tgt, logic nt);
    int       gap;
    in_item_t it;
    it.measured_position = meas;
    it.target_position = tgt;
    it.new_target = nt;
    gap = draw_gap();
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_if.data <= it;
    tick_if.valid <= 1'b1;
    do @(posedge clk); while (!tick_if.ready);
    pending_cmds.push_back(advance_profile(it));
    ticks_sent++;
  endtask

  // stop sending and wait until every command has come back
  task automatic settle();
    tick_if.valid <= 1'b0;
    do @(posedge clk); while (pending_cmds.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDatW-1:0] val);
    cfg_item_t w;
    w.addr = idx;
    w.wdata = val;
    cfg_if.data <= w;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_MAX_VELOCITY: max_vel_q = val[CfgW-1:0];
      CFG_ACCEL_RATE:   accel_rate_q = val[CfgW-1:0];
      CFG_ACCEL_STEP:   accel_step_q = val[CfgW-1:0];
      CFG_DEADBAND:     deadband_q = val[CfgW-1:0];
      CFG_AUTO_HOLD:    auto_hold_q = val[0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [31:0] mv, logic [31:0] ar, logic [31:0] as,
                           logic [31:0] db, logic ah);
    write_reg(CFG_MAX_VELOCITY, mv);
    write_reg(CFG_ACCEL_RATE, ar);
    write_reg(CFG_ACCEL_STEP, as);
    write_reg(CFG_DEADBAND, db);
    write_reg(CFG_AUTO_HOLD, {31'd0, ah});
    cfg_if.valid <= 1'b0;
  endtask

  // spread magnitudes; the top bit is outside the register and must be ignored
  function automatic logic [31:0] rand_reg(bit nonzero);
    logic [31:0] w;
    w = $urandom >> $urandom_range(0, 31);
    w[31] = ($urandom_range(0, 7) == 0);
    if (nonzero && w[30:0] == '0) w[0] = 1'b1;
    return w;
  endfunction

  // reset defaults: up and down moves, error on the deadband edge,
  // arrival while accelerating
  task automatic test_default_moves();
    send_tick(32'sh0000_0000, 32'sh0010_0000, 1'b1);
    send_tick(32'sh0000_0000, 32'sh0010_0000, 1'b0);
    send_tick(32'sh0010_0000 - 3277, 32'sh0010_0000, 1'b0);
    send_tick(32'sh0010_0000, 32'sh0010_0000, 1'b0);
    send_tick(32'sh0010_0000, 32'sh0000_0000, 1'b0);
    send_tick(32'sh0010_0000, 32'sh0010_0000 + 3277, 1'b0);
    send_tick(32'sh0010_0000, 32'sh0010_0000 - 100, 1'b0);
  endtask

  // auto-hold latches on arrival and only a new target releases it
  task automatic test_arrival_hold();
    settle();
    load_regs(32'd3932160, 32'd13107200, 32'd13107, 32'h0001_0000, 1'b1);
    send_tick(32'sh0000_0000, 32'sh0100_0000, 1'b1);
    send_tick(32'sh00FF_FFFF, 32'sh0100_0000, 1'b0);
    send_tick(32'sh0000_0000, 32'sh0100_0000, 1'b0);
    send_tick(32'sh0200_0000, 32'sh0100_0000, 1'b0);
    send_tick(32'sh0000_0000, 32'sh0100_0000, 1'b1);
  endtask

  // velocity arithmetic clamps at the 32-bit limits
  task automatic test_saturation();
    settle();
    load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd0, 1'b0);
    send_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    settle();
    load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 1'b0);
    send_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_tick(32'sh8000_0005, 32'sh8000_0000, 1'b0);
  endtask

  // zero limits, minimum accel rate, widest deadband
  task automatic test_field_extremes();
    settle();
    load_regs(32'd0, 32'd1, 32'd0, 32'h7FFF_FFFF, 1'b0);
    send_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    send_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_tick(-32'sd1, 32'sh0000_0000, 1'b0);
  endtask

  // moves toward random targets with a plant that follows the command,
  // mixed with bursts of arbitrary ticks
  task automatic test_random_moves();
    logic [31:0]            mv;
    int                     sh;
    int                     len;
    int                     jit;
    int unsigned            stop_at;
    bit                     held_off;
    longint                 span;
    logic signed [31:0]     tgt;
    logic signed [31:0]     cur;
    held_off = 1'b0;
    for (int round = 0; round < 6; round++) begin
      settle();
      no_idle = (round == 3);
      sh = $urandom_range(0, 4);
      if (round == 0) begin
        load_regs(rand_reg(0), rand_reg(1), rand_reg(0), rand_reg(0), 1'($urandom_range(0, 1)));
      end else begin
        mv = (32'd1 << $urandom_range(8, 28)) + $urandom_range(0, 255);
        load_regs(mv, (mv >> $urandom_range(0, 8)) + 1, (mv >> $urandom_range(0, 5)) + 1,
                  (mv >> sh) >> $urandom_range(0, 6), 1'($urandom_range(0, 1)));
      end
      stop_at = ticks_sent + 60;
      while (ticks_sent < stop_at) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4)) send_tick($urandom, $urandom, 1'($urandom_range(0, 1)));
        end else begin
          span = (longint'(max_vel_q) >>> sh) * $urandom_range(1, 60) + $urandom_range(0, 1000);
          tgt = $urandom;
          cur = sat32(longint'(tgt) + ($urandom_range(0, 1) ? span : -span));
          len = $urandom_range(8, 60);
          for (int k = 0; k < len; k++) begin
            send_tick(cur, tgt, k == 0 || $urandom_range(0, 49) == 0);
            jit = $urandom_range(0, 2);
            cur = sat32(longint'(cur) + (longint'(vel_q) >>> sh) + jit - 1);
          end
        end
        // hold the sender once mid-run until every command is back
        if (round == 2 && !held_off) begin
          settle();
          held_off = 1'b1;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    max_vel_q = MaxVelRst;
    accel_rate_q = AccelRateRst;
    accel_step_q = AccelStepRst;
    deadband_q = DeadbandRst;
    auto_hold_q = 1'b0;
    vel_q = '0;
    phase_q = PH_NONE;
    ticks_sent = 0;
    no_idle = 1'b0;
    rst_n <= 1'b0;
    tick_if.valid <= 1'b0;
    tick_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_moves();
    test_arrival_hold();
    test_saturation();
    test_field_extremes();
    test_random_moves();
    settle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tvp_pkg.sv
rtl/tvp_stream_if.sv
rtl/tvp_digit_mul.sv
rtl/trapezoid_velocity_profiler_core.sv
tb/sv/tb.sv
